// File: rtl/core/dnsrt_pkg.sv
`default_nettype none

package dnsrt_pkg;

   // table geometry
   localparam int BUCKETS = 256;
   localparam int WAYS    = 4;
   localparam int POOLS   = 8;
   localparam int ENTRIES = BUCKETS * WAYS;

   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int BUCKET_W = 8;
   localparam int KEY_W    = 19;
   localparam int COUNT_W  = 11;

   localparam logic [BUCKET_W-1:0] HASH_SEED = 8'hac;
   localparam logic [COUNT_W-1:0]  COUNT_MAX = 11'd2047;
   localparam logic [7:0]          TIMEOUT_RESET = 8'd5;

   // request kinds
   localparam logic [1:0] REQ_STORE    = 2'd0;
   localparam logic [1:0] REQ_RETRIEVE = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;

   // response status codes
   localparam logic [2:0] ST_STORED = 3'd0;
   localparam logic [2:0] ST_HIT    = 3'd1;
   localparam logic [2:0] ST_MISS   = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_TICK   = 3'd4;

   // one table entry as held in the entry ram
   typedef struct packed {
      logic             valid;
      logic [7:0]       timer;
      logic [KEY_W-1:0] key;
      logic [31:0]      addr;
      logic [15:0]      port;
   } entry_type;

   // access to the entry ram for one cycle
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

// File: rtl/core/dnsrt_entry_ram.sv
`default_nettype none

module dnsrt_entry_ram
   import dnsrt_pkg::*;
(
   input  wire         clock,
   input  ram_req_type ram_req,
   output entry_type   rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/dns_request_id_tracker.sv
`default_nettype none

// Table of outstanding DNS requests, keyed by DNS id and pool index, holding
// the client address and port. All entries live in one entry ram with one
// write and one read port that a small sequencer walks one entry at a time;
// the block takes one request at a time. After reset a clearing pass over all
// ENTRIES frees every entry, and no request is taken meanwhile (csr writes are).
// A store or retrieve probes the ways of its bucket in order, each way as a
// ram read followed by a check and write back; a request for an unknown pool
// or an unused kind answers as a miss without touching the ram. An aging tick
// sweeps every entry through the same read and write-back loop. The result
// sits in an output register, so a new request may be accepted while the
// previous response still waits to be taken.

module dns_request_id_tracker
   import dnsrt_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,   // pool_id, dns_id, client_addr, client_port
   input  wire  [1:0]  req_tuser,   // req_type
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // found_addr, found_port, active_count
   output logic [2:0]  rsp_tuser,   // status
   // configuration: timeout_ticks
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_data
);

   typedef enum logic [6:0] {
      S_CLEAR    = 7'b0000001,
      S_IDLE     = 7'b0000010,
      S_RD       = 7'b0000100,
      S_CHK      = 7'b0001000,
      S_TICK_RD  = 7'b0010000,
      S_TICK_CHK = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]   idx_ff, idx_in;       // clear and tick sweep index
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [WAY_W-1:0]   way_ff, way_in;
   logic [1:0]         kind_ff, kind_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [31:0]        addr_ff, addr_in;
   logic [15:0]        port_ff, port_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]         timeout_ff, timeout_in;

   logic [2:0]         res_status_ff, res_status_in;
   logic [31:0]        res_addr_ff, res_addr_in;
   logic [15:0]        res_port_ff, res_port_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_addr_ff, rsp_addr_in;
   logic [15:0]        rsp_port_ff, rsp_port_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   ram_req_type ram_req;
   entry_type   rd_data;

   // request fields
   logic [2:0]          f_pool;
   logic [15:0]         f_id;
   logic [31:0]         f_addr;
   logic [15:0]         f_port;
   logic [BUCKET_W-1:0] f_bucket;

   logic [IDX_W-1:0] way_idx;
   logic             way_last;
   logic             key_eq;
   logic             slot_free;
   logic             req_accept;

   assign f_pool   = req_tdata[2:0];
   assign f_id     = req_tdata[18:3];
   assign f_addr   = req_tdata[50:19];
   assign f_port   = req_tdata[66:51];
   assign f_bucket = HASH_SEED ^ f_id[15:8] ^ f_id[7:0];

   assign way_idx  = base_ff + IDX_W'(way_ff);
   assign way_last = (way_ff == WAY_W'(WAYS - 1));
   assign key_eq   = (rd_data.key == key_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign csr_ready = 1'b1;

   dnsrt_entry_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // configuration register
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_valid) begin
         timeout_in = csr_data;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      way_in        = way_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_port_in   = res_port_ff;
      res_count_in  = res_count_ff;

      ram_req         = '0;
      ram_req.rd_addr = (state_ff == S_RD) ? way_idx : idx_ff;
      ram_req.wr_addr = way_idx;
      ram_req.wr_data = rd_data;

      unique case (state_ff)
         S_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff;
            ram_req.wr_data = '0;
            idx_in          = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               kind_in       = req_tuser;
               key_in        = {f_pool, f_id};
               addr_in       = f_addr;
               port_in       = f_port;
               base_in       = IDX_W'(int'(f_bucket) * WAYS);
               way_in        = '0;
               idx_in        = '0;
               cnt_in        = '0;
               res_addr_in   = '0;
               res_port_in   = '0;
               res_count_in  = '0;
               if (req_tuser == REQ_TICK) begin
                  state_in = S_TICK_RD;
               end else if ((req_tuser == REQ_STORE || req_tuser == REQ_RETRIEVE)
                            && (int'(f_pool) < POOLS)) begin
                  state_in = S_RD;
               end else begin
                  res_status_in = ST_MISS;
                  state_in      = S_DONE;
               end
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (kind_ff == REQ_STORE) begin
               // first way that is free or holds the same key
               if (!rd_data.valid || key_eq) begin
                  ram_req.wr_en         = 1'b1;
                  ram_req.wr_data.valid = 1'b1;
                  ram_req.wr_data.timer = timeout_ff;
                  ram_req.wr_data.key   = key_ff;
                  ram_req.wr_data.addr  = addr_ff;
                  ram_req.wr_data.port  = port_ff;
                  res_status_in         = ST_STORED;
                  state_in              = S_DONE;
               end else if (way_last) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = S_RD;
               end
            end else begin
               // retrieve frees the first valid match
               if (rd_data.valid && key_eq) begin
                  ram_req.wr_en         = 1'b1;
                  ram_req.wr_data.valid = 1'b0;
                  res_status_in         = ST_HIT;
                  res_addr_in           = rd_data.addr;
                  res_port_in           = rd_data.port;
                  state_in              = S_DONE;
               end else if (way_last) begin
                  res_status_in = ST_MISS;
                  state_in      = S_DONE;
               end else begin
                  way_in   = way_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_TICK_RD: begin
            state_in = S_TICK_CHK;
         end
         S_TICK_CHK: begin
            // age one entry and write it back
            ram_req.wr_addr = idx_ff;
            if (rd_data.valid) begin
               ram_req.wr_en = 1'b1;
               if (rd_data.timer <= 8'd1) begin
                  ram_req.wr_data.valid = 1'b0;
               end else begin
                  ram_req.wr_data.timer = rd_data.timer - 8'd1;
                  if (cnt_ff < COUNT_MAX) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(ENTRIES - 1)) begin
               res_status_in = ST_TICK;
               res_count_in  = cnt_in;
               state_in      = S_DONE;
            end else begin
               state_in = S_TICK_RD;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_DONE) && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_addr_in   = res_addr_ff;
         rsp_port_in   = res_port_ff;
         rsp_count_in  = res_count_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         timeout_ff   <= timeout_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      way_ff        <= way_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      addr_ff       <= addr_in;
      port_ff       <= port_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_port_ff   <= res_port_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_port_ff, rsp_addr_ff};

endmodule

`default_nettype wire

// File: tb/sv/dns_request_id_tracker_tb.sv
`timescale 1ns / 1ps

module dns_request_id_tracker_tb;
   import dnsrt_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 12;
   localparam int MAX_CYCLES   = 4_000_000;
   localparam int TAIL_CYCLES  = 24;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 110;
   localparam int HOT_N        = 12;
   localparam int DIRECTED_N   = 22;
   localparam int ERROR_PRINTS = 100;

   // request kind with no meaning, answered as a miss
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // marks a table row whose response comes from the table model
   localparam logic [2:0] WANT_PREDICTED = 3'd7;

   // one request as sent, with an optional status known up front
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  pool;
      logic [15:0] id;
      logic [31:0] addr;
      logic [15:0] port;
      logic [2:0]  want_status;
   } req_item_type;

   // one response, field by field
   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        addr;
      logic [15:0]        port;
      logic [COUNT_W-1:0] count;
   } rsp_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;   // pool_id, dns_id, client_addr, client_port
   logic [1:0]  req_tuser  = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // found_addr, found_port, active_count
   logic [2:0]  rsp_tuser;         // status
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   // own copy of the request table
   bit               tbl_valid [ENTRIES];
   bit [KEY_W-1:0]   tbl_key   [ENTRIES];
   bit [31:0]        tbl_addr  [ENTRIES];
   bit [15:0]        tbl_port  [ENTRIES];
   bit [7:0]         tbl_timer [ENTRIES];
   logic [7:0]       model_timeout = TIMEOUT_RESET;

   req_item_type     sent_q [$];
   rsp_item_type     awaited_q [$];
   int               error_count    = 0;
   int               cycle_count    = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   logic [2:0]       hot_pool [HOT_N];
   logic [15:0]      hot_id   [HOT_N];

   // directed rows: all ids with equal bytes fall in one bucket
   req_item_type directed_tbl [DIRECTED_N] = '{
      {REQ_RETRIEVE, 3'd0, 16'h0000, 32'h00000000, 16'h0000, ST_MISS},
      {REQ_TICK,     3'd0, 16'h0000, 32'h00000000, 16'h0000, ST_TICK},
      {REQ_UNUSED,   3'd7, 16'hffff, 32'hffffffff, 16'hffff, ST_MISS},
      {REQ_STORE,    3'd0, 16'h0000, 32'h00000000, 16'h0000, ST_STORED},
      {REQ_STORE,    3'd7, 16'hffff, 32'hffffffff, 16'hffff, ST_STORED},
      {REQ_STORE,    3'd3, 16'h1212, 32'h12345678, 16'h1234, ST_STORED},
      {REQ_STORE,    3'd5, 16'hacac, 32'hdeadbeef, 16'hbeef, ST_STORED},
      {REQ_STORE,    3'd1, 16'h3434, 32'h55aa55aa, 16'haa55, ST_FULL},
      {REQ_STORE,    3'd7, 16'hffff, 32'ha5a5a5a5, 16'h5a5a, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd7, 16'hffff, 32'hffffffff, 16'hffff, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd7, 16'hffff, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd0, 16'hffff, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd0, 16'h0000, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_STORE,    3'd5, 16'hacac, 32'h0badf00d, 16'hf00d, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd5, 16'hacac, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd5, 16'hacac, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_TICK,     3'd7, 16'hffff, 32'hffffffff, 16'hffff, WANT_PREDICTED},
      {REQ_TICK,     3'd0, 16'h0000, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_TICK,     3'd0, 16'h0000, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_TICK,     3'd0, 16'h0000, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_TICK,     3'd0, 16'h0000, 32'h00000000, 16'h0000, WANT_PREDICTED},
      {REQ_RETRIEVE, 3'd3, 16'h1212, 32'h00000000, 16'h0000, WANT_PREDICTED}
   };

   dns_request_id_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("dns_request_id_tracker_tb: done, errors");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic note_error(input string msg);
      if (error_count < ERROR_PRINTS)
         $display("%0t: %s", $time, msg);
      error_count = error_count + 1;
   endtask

   function automatic logic [BUCKET_W-1:0] bucket_index(input logic [15:0] id);
      return HASH_SEED ^ id[15:8] ^ id[7:0];
   endfunction

   // apply one request to the table copy and work out its response
   task automatic track_request(input req_item_type r, output rsp_item_type e);
      int               base;
      int               cnt;
      int               i;
      bit               done;
      logic [KEY_W-1:0] k;
      e        = '0;
      e.status = ST_MISS;
      k        = {r.pool, r.id};
      base     = int'(bucket_index(r.id)) * WAYS;
      cnt      = 0;
      done     = 1'b0;
      case (r.kind)
         REQ_TICK: begin
            // age every live entry, an expiring timer frees it
            for (int n = 0; n < ENTRIES; n++) begin
               if (tbl_valid[n]) begin
                  if (tbl_timer[n] <= 8'd1) begin
                     tbl_valid[n] = 1'b0;
                  end else begin
                     tbl_timer[n] = tbl_timer[n] - 8'd1;
                     if (cnt < int'(COUNT_MAX))
                        cnt = cnt + 1;
                  end
               end
            end
            e.status = ST_TICK;
            e.count  = cnt[COUNT_W-1:0];
         end
         REQ_STORE: begin
            if (int'(r.pool) < POOLS) begin
               // first way that is free or holds the same key
               for (int w = 0; w < WAYS; w++) begin
                  i = base + w;
                  if (!done && (!tbl_valid[i] || tbl_key[i] == k)) begin
                     tbl_valid[i] = 1'b1;
                     tbl_key[i]   = k;
                     tbl_addr[i]  = r.addr;
                     tbl_port[i]  = r.port;
                     tbl_timer[i] = model_timeout;
                     done         = 1'b1;
                  end
               end
               e.status = done ? ST_STORED : ST_FULL;
            end
         end
         REQ_RETRIEVE: begin
            if (int'(r.pool) < POOLS) begin
               // lowest matching way answers and is freed
               for (int w = 0; w < WAYS; w++) begin
                  i = base + w;
                  if (!done && tbl_valid[i] && tbl_key[i] == k) begin
                     tbl_valid[i] = 1'b0;
                     e.status     = ST_HIT;
                     e.addr       = tbl_addr[i];
                     e.port       = tbl_port[i];
                     done         = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // response check first, then the request taken at the same edge
   always @(posedge clock) begin : monitor_blk
      req_item_type r;
      rsp_item_type e;
      rsp_item_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32], rsp_tdata[58:48]};
            if (awaited_q.size() == 0) begin
               note_error($sformatf("response with nothing awaited, status %0d",
                                    got.status));
            end else begin
               e = awaited_q.pop_front();
               if (got.status != e.status)
                  note_error($sformatf("status got %0d want %0d", got.status, e.status));
               if (got.addr != e.addr)
                  note_error($sformatf("found_addr got %h want %h", got.addr, e.addr));
               if (got.port != e.port)
                  note_error($sformatf("found_port got %h want %h", got.port, e.port));
               if (got.count != e.count)
                  note_error($sformatf("active_count got %0d want %0d",
                                       got.count, e.count));
            end
         end
         if (req_tvalid && req_tready && sent_q.size() != 0) begin
            r = sent_q.pop_front();
            track_request(r, e);
            if (r.want_status != WANT_PREDICTED)
               e = {r.want_status, 59'd0};
            awaited_q.push_back(e);
         end
      end
   end

   // drive one request, idling first at random
   task automatic send_request(input req_item_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {5'd0, r.port, r.addr, r.id, r.pool};
      sent_q.push_back(r);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_timeout(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      model_timeout = v;
   endtask

   // sampled at the falling edge so the monitor has settled
   task automatic wait_drained();
      do @(negedge clock); while (awaited_q.size() != 0 || sent_q.size() != 0);
      @(posedge clock);
   endtask

   // two crowded buckets, some ids shared between pools
   task automatic pick_hot_keys();
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b;
      logic [7:0] hi;
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      for (int j = 0; j < HOT_N; j++) begin
         b  = (j < HOT_N / 2) ? b0 : b1;
         hi = 8'($urandom);
         if (j % 3 == 2)
            hot_id[j] = hot_id[j - 1];
         else
            hot_id[j] = {hi, b ^ HASH_SEED ^ hi};
         hot_pool[j] = 3'($urandom_range(7));
      end
   endtask

   task automatic random_request(output req_item_type r);
      int pick;
      int j;
      pick          = $urandom_range(99);
      r.kind        = REQ_STORE;
      r.pool        = 3'($urandom_range(7));
      r.id          = 16'($urandom);
      r.addr        = $urandom;
      r.port        = 16'($urandom);
      r.want_status = WANT_PREDICTED;
      if (pick < 4) begin
         r.kind = REQ_TICK;
      end else if (pick < 7) begin
         r.kind = REQ_UNUSED;
      end else begin
         r.kind = ($urandom_range(99) < 55) ? REQ_STORE : REQ_RETRIEVE;
         if ($urandom_range(99) < 75) begin
            j      = $urandom_range(HOT_N - 1);
            r.pool = hot_pool[j];
            r.id   = hot_id[j];
         end
      end
   endtask

   // main sequence
   initial begin : main_blk
      req_item_type r;
      int           served;
      logic [7:0]   timeout_plan [PHASES];
      timeout_plan = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd0, 8'd3, TIMEOUT_RESET, 8'd0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset timeout, no idling
      for (int n = 0; n < DIRECTED_N; n++)
         send_request(directed_tbl[n]);
      req_tvalid <= 1'b0;
      wait_drained();

      // random phases, each with its own timeout and idling mix
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         if (p == 4 || p == 7)
            write_timeout(8'($urandom_range(255, 1)));
         else
            write_timeout(timeout_plan[p]);
         pick_hot_keys();
         served = 0;
         while (served < PHASE_ITEMS) begin
            random_request(r);
            send_request(r);
            if (r.kind != REQ_UNUSED)
               served = served + 1;
         end
         req_tvalid <= 1'b0;
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("dns_request_id_tracker_tb: done, clean");
      else
         $display("dns_request_id_tracker_tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
rtl/core/dnsrt_pkg.sv
rtl/core/dnsrt_entry_ram.sv
rtl/core/dns_request_id_tracker.sv
tb/sv/dns_request_id_tracker_tb.sv
